// File: hw/rtl/tstg_pkg.sv
// Package for the timed square tone generator.
// Holds widths, time constants, mode codes, sequencer states and divider control types.
// No dependencies.
package tstg_pkg;

  localparam int TICK_BITS   = 32;
  localparam int FREQ_W      = 15;
  localparam int DUR_W       = 16;
  localparam int HP_W        = 19;
  localparam int REMAIN_W    = 26;
  localparam int HP_DIV_BITS = 20;
  localparam int STEP_W      = $clog2(TICK_BITS + 1);

  localparam int US_PER_SEC = 1000000;
  localparam int US_PER_MS  = 1000;

  localparam logic [TICK_BITS-1:0] HP_DIVIDEND =
    TICK_BITS'(US_PER_SEC) << (TICK_BITS - HP_DIV_BITS);

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_HP,
    ST_DIV_REM
  } tstg_state_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

// File: hw/rtl/tstg_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on tstg_pkg for widths and the control/status structs.
module tstg_div
  import tstg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  div_ctl_t             ctl,
  input  logic [TICK_BITS-1:0] dividend,
  input  logic [HP_W-1:0]      divisor,
  output div_sts_t             sts,
  output logic [TICK_BITS-1:0] quotient,
  output logic [HP_W-1:0]      remainder
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [STEP_W-1:0]    cnt_r, cnt_nxt;
  logic [HP_W-1:0]      rem_r, rem_nxt;
  logic [TICK_BITS-1:0] quo_r, quo_nxt;
  logic [HP_W-1:0]      dsr_r, dsr_nxt;
  logic [HP_W:0]        shifted;
  logic [HP_W:0]        diff;
  logic                 ge;

  always_comb begin
    shifted  = {rem_r, quo_r[TICK_BITS-1]};
    ge       = shifted >= {1'b0, dsr_r};
    diff     = shifted - {1'b0, dsr_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = ctl.steps;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[HP_W-1:0] : shifted[HP_W-1:0];
      quo_nxt = {quo_r[TICK_BITS-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign sts.busy  = busy_r;
  assign sts.done  = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// File: hw/rtl/timed_square_tone_generator_unit.sv
// Timed square tone generator top level: tick counter, note state and sequencer.
// Depends on tstg_pkg and tstg_div.
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_stall   in_mode, in_freq_hz, in_duration_ms
//   out_     output     out_valid/out_stall out_speaker_level, out_playing, out_note_done
//
// A tick beat or a start beat with zero duration or zero frequency bypasses the divider.
// A start beat with a tone runs the shared divider 20 steps for the half period,
// then TICK_BITS steps for the phase remainder of the tick counter.
// Synchronous active-low reset clears the counter and note state; the pin starts low.
// in_stall is high while the divider works or while a result beat waits under out_stall.
module timed_square_tone_generator_unit
  import tstg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_mode,
  input  logic [FREQ_W-1:0] in_freq_hz,
  input  logic [DUR_W-1:0]  in_duration_ms,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_speaker_level,
  output logic              out_playing,
  output logic              out_note_done
);

  tstg_state_t          state_r, state_nxt;
  logic [TICK_BITS-1:0] tick_count_r, tick_count_nxt;
  logic [HP_W-1:0]      hp_r, hp_nxt;
  logic [HP_W-1:0]      cd_r, cd_nxt;
  logic [REMAIN_W-1:0]  remain_r, remain_nxt;
  logic                 active_r, active_nxt;
  logic                 pin_r, pin_nxt;
  logic                 phase_r, phase_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_level_r, out_level_nxt;
  logic                 out_playing_r, out_playing_nxt;
  logic                 out_done_r, out_done_nxt;

  logic                 accept;
  logic                 load_out;
  logic                 done_bit;
  logic [HP_W-1:0]      cd_dec;
  logic [REMAIN_W-1:0]  remain_dec;

  div_ctl_t             div_ctl;
  div_sts_t             div_sts;
  logic [TICK_BITS-1:0] div_dividend;
  logic [HP_W-1:0]      div_divisor;
  logic [TICK_BITS-1:0] div_quo;
  logic [HP_W-1:0]      div_rem;

  assign in_stall = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;

  tstg_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (div_ctl),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .sts       (div_sts),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_comb begin
    state_nxt      = state_r;
    tick_count_nxt = tick_count_r;
    hp_nxt         = hp_r;
    cd_nxt         = cd_r;
    remain_nxt     = remain_r;
    active_nxt     = active_r;
    pin_nxt        = pin_r;
    phase_nxt      = phase_r;
    load_out       = 1'b0;
    done_bit       = 1'b0;
    cd_dec         = cd_r - 1'b1;
    remain_dec     = remain_r - 1'b1;
    div_ctl        = '0;
    div_dividend   = HP_DIVIDEND;
    div_divisor    = {{(HP_W - FREQ_W - 1){1'b0}}, in_freq_hz, 1'b0};

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_mode == MODE_TICK) begin
            tick_count_nxt = tick_count_r + 1'b1;
            if (active_r) begin
              if (hp_r != '0) begin
                if (cd_dec == '0) begin
                  phase_nxt = ~phase_r;
                  pin_nxt   = ~phase_r;
                  cd_nxt    = hp_r;
                end else begin
                  cd_nxt = cd_dec;
                end
              end
              remain_nxt = remain_dec;
              if (remain_dec == '0) begin
                active_nxt = 1'b0;
                done_bit   = 1'b1;
              end
            end
            load_out = 1'b1;
          end else if (in_duration_ms != '0) begin
            remain_nxt = REMAIN_W'(in_duration_ms) * REMAIN_W'(US_PER_MS);
            phase_nxt  = 1'b0;
            active_nxt = 1'b1;
            if (in_freq_hz == '0) begin
              hp_nxt   = '0;
              cd_nxt   = '0;
              load_out = 1'b1;
            end else begin
              div_ctl.start = 1'b1;
              div_ctl.steps = STEP_W'(HP_DIV_BITS);
              state_nxt     = ST_DIV_HP;
            end
          end else begin
            load_out = 1'b1;
          end
        end
      end
      ST_DIV_HP: begin
        div_dividend = tick_count_r;
        div_divisor  = div_quo[HP_W-1:0];
        if (div_sts.done) begin
          hp_nxt        = div_quo[HP_W-1:0];
          div_ctl.start = 1'b1;
          div_ctl.steps = STEP_W'(TICK_BITS);
          state_nxt     = ST_DIV_REM;
        end
      end
      ST_DIV_REM: begin
        if (div_sts.done) begin
          cd_nxt    = hp_r - div_rem;
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_valid_nxt   = out_valid_r;
    out_level_nxt   = out_level_r;
    out_playing_nxt = out_playing_r;
    out_done_nxt    = out_done_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt   = 1'b1;
      out_level_nxt   = pin_nxt;
      out_playing_nxt = active_nxt;
      out_done_nxt    = done_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      tick_count_r <= '0;
      hp_r         <= '0;
      cd_r         <= '0;
      remain_r     <= '0;
      active_r     <= 1'b0;
      pin_r        <= 1'b0;
      phase_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      tick_count_r <= tick_count_nxt;
      hp_r         <= hp_nxt;
      cd_r         <= cd_nxt;
      remain_r     <= remain_nxt;
      active_r     <= active_nxt;
      pin_r        <= pin_nxt;
      phase_r      <= phase_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_level_r   <= out_level_nxt;
    out_playing_r <= out_playing_nxt;
    out_done_r    <= out_done_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_speaker_level = out_level_r;
  assign out_playing       = out_playing_r;
  assign out_note_done     = out_done_r;

  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> state_r == ST_IDLE)
    else $error("beat accepted while divider sequence runs");

  a_time_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |=> $stable(tick_count_r))
    else $error("tick counter moved during division");

  a_countdown_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && active_r && hp_r != '0) |-> (cd_r != '0 && cd_r <= hp_r))
    else $error("toggle countdown out of range");

  a_done_ends_note: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_done_r) |-> !out_playing_r)
    else $error("note_done reported while note still plays");

endmodule
